// ===== sv/ppsf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsf_pkg
// Shared types, widths and default sizes for the ping-pong stream feeder.
// ----------------------------------------------------------------------------
package ppsf_pkg;

	localparam int unsigned SLOT_COUNT_DEF  = 2;
	localparam int unsigned SLOT_BYTES_DEF  = 4096;
	localparam int unsigned CHUNK_BYTES_DEF = 32;

	localparam int unsigned KIND_W   = 4;
	localparam int unsigned SIZE_W   = 13;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned LENGTH_W = 6;
	localparam int unsigned TOTAL_W  = 32;

	typedef enum logic [KIND_W-1:0] {
		K_ACQUIRE = 4'd0,
		K_COMMIT  = 4'd1,
		K_CANCEL  = 4'd2,
		K_PIN     = 4'd3,
		K_DONE    = 4'd4,
		K_ERROR   = 4'd5,
		K_PAUSE   = 4'd6,
		K_RESUME  = 4'd7,
		K_ABORT   = 4'd8,
		K_REINIT  = 4'd9
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_PARAM = 2'd1,
		ST_NOT_READY = 2'd2,
		ST_BUSY      = 2'd3
	} status_t;

	// per-slot lifecycle, one-hot
	typedef enum logic [3:0] {
		SL_EMPTY   = 4'b0001,
		SL_WRITING = 4'b0010,
		SL_READY   = 4'b0100,
		SL_ACTIVE  = 4'b1000
	} slot_st_t;

endpackage

// ===== sv/ppsf_rr_pick.sv =====
// ----------------------------------------------------------------------------
// ppsf_rr_pick
// Round-robin pick: first requesting slot at or after the start index.
// ----------------------------------------------------------------------------
module ppsf_rr_pick #(
	parameter int unsigned SLOT_COUNT = 2,
	localparam int unsigned IW = $clog2(SLOT_COUNT)
) (
	input  logic [SLOT_COUNT-1:0] req,
	input  logic [IW-1:0]         first,
	output logic                  found,
	output logic [IW-1:0]         pick
);

	always_comb begin
		logic [IW:0] idx;
		found = 1'b0;
		pick  = '0;
		// walk from the far end so the nearest request wins
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			idx = (IW+1)'(first) + (IW+1)'(s);
			if (idx >= (IW+1)'(SLOT_COUNT)) begin
				idx = idx - (IW+1)'(SLOT_COUNT);
			end
			if (req[idx[IW-1:0]]) begin
				found = 1'b1;
				pick  = idx[IW-1:0];
			end
		end
	end

endmodule

// ===== sv/ping_pong_stream_feeder.sv =====
// ----------------------------------------------------------------------------
// ping_pong_stream_feeder
// Descriptor manager for a ring of payload slots drained into a sink in chunks.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  -------------------------------------
//  command   start, busy (always low)  kind, commit_size, sink_ready
//  result    done (one-cycle strobe)   status, granted, grant_slot, dma_*,
//                                      in_flight, idle, bytes_sent
//
//  One command is taken every cycle; busy never rises.
//  Each command is captured in the input register, is decoded against the
//  slot table in a single pass, and its result is registered in the result
//  register, which drives done and the result ports.
//  Done marks each result for exactly one cycle; the receiver cannot stall it.
//  Reset (arst_n low) empties all slots, clears the running total and marks
//  the decoder not ready until a reinit command arrives.
//
module ping_pong_stream_feeder #(
	parameter int unsigned SLOT_COUNT  = ppsf_pkg::SLOT_COUNT_DEF,
	parameter int unsigned SLOT_BYTES  = ppsf_pkg::SLOT_BYTES_DEF,
	parameter int unsigned CHUNK_BYTES = ppsf_pkg::CHUNK_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ppsf_pkg::KIND_W-1:0]   kind,
	input  logic [ppsf_pkg::SIZE_W-1:0]   commit_size,
	input  logic                          sink_ready,
	output logic                          done,
	output logic [ppsf_pkg::STATUS_W-1:0] status,
	output logic                          granted,
	output logic                          grant_slot,
	output logic                          dma_start,
	output logic                          dma_slot,
	output logic [ppsf_pkg::OFFSET_W-1:0] dma_offset,
	output logic [ppsf_pkg::LENGTH_W-1:0] dma_length,
	output logic                          dma_stop,
	output logic                          in_flight,
	output logic                          idle,
	output logic [ppsf_pkg::TOTAL_W-1:0]  bytes_sent
);

	import ppsf_pkg::*;

	localparam int unsigned IW = $clog2(SLOT_COUNT);
	localparam int unsigned PW = $clog2(CHUNK_BYTES + 1);

	// ---------------- input register ----------------
	logic              valid_s1;
	kind_t             kind_s1;
	logic [SIZE_W-1:0] size_s1;
	logic              pin_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			kind_s1 <= kind_t'(kind);
			size_s1 <= commit_size;
			pin_s1  <= sink_ready;
		end
	end

	// ---------------- stream state ----------------
	slot_st_t            slot_state_q [SLOT_COUNT];
	logic [SIZE_W-1:0]   slot_fill_q  [SLOT_COUNT];
	logic [SIZE_W-1:0]   slot_sent_q  [SLOT_COUNT];
	logic                held_valid_q;
	logic [IW-1:0]       held_slot_q;
	logic                act_valid_q;
	logic [IW-1:0]       act_slot_q;
	logic [IW-1:0]       next_wr_q;
	logic [IW-1:0]       next_rd_q;
	logic                tx_q;
	logic                paused_q;
	logic [PW-1:0]       pend_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                dnr_q;

	// acquire scan over the current table
	logic [SLOT_COUNT-1:0] empty_vec;
	logic                  wr_found;
	logic [IW-1:0]         wr_pick;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			empty_vec[i] = (slot_state_q[i] == SL_EMPTY);
		end
	end

	ppsf_rr_pick #(.SLOT_COUNT(SLOT_COUNT)) u_wr_pick (
		.req   (empty_vec),
		.first (next_wr_q),
		.found (wr_found),
		.pick  (wr_pick)
	);

	// ---------------- event step ----------------
	// a_* is the state once the command itself is applied, before any feed.
	slot_st_t           a_state [SLOT_COUNT];
	logic [SIZE_W-1:0]  a_fill  [SLOT_COUNT];
	logic [SIZE_W-1:0]  a_sent  [SLOT_COUNT];
	logic               a_held_v, a_act_v, a_tx, a_paused, a_dnr;
	logic [IW-1:0]      a_held, a_act, a_nw, a_nr;
	logic [PW-1:0]      a_pend;
	logic [TOTAL_W-1:0] a_total;
	logic               want_feed;
	status_t            r_status;
	logic               r_granted, r_gslot, r_stop;

	always_comb begin
		logic [SIZE_W-1:0] sum;
		logic              wide_bad;
		a_state  = slot_state_q;
		a_fill   = slot_fill_q;
		a_sent   = slot_sent_q;
		a_held_v = held_valid_q;
		a_held   = held_slot_q;
		a_act_v  = act_valid_q;
		a_act    = act_slot_q;
		a_nw     = next_wr_q;
		a_nr     = next_rd_q;
		a_tx     = tx_q;
		a_paused = paused_q;
		a_pend   = pend_q;
		a_total  = total_q;
		a_dnr    = dnr_q;
		want_feed = 1'b0;
		r_status  = ST_OK;
		r_granted = 1'b0;
		r_gslot   = 1'b0;
		r_stop    = 1'b0;
		sum       = '0;
		wide_bad  = (size_s1 == '0) || (32'(size_s1) > 32'(SLOT_BYTES));

		case (kind_s1)
			K_ACQUIRE: begin
				if (dnr_q) begin
					r_status = ST_NOT_READY;
				end else if (held_valid_q || !wr_found) begin
					r_status = ST_BUSY;
				end else begin
					a_state[wr_pick] = SL_WRITING;
					a_fill[wr_pick]  = '0;
					a_sent[wr_pick]  = '0;
					a_held_v  = 1'b1;
					a_held    = wr_pick;
					a_nw      = (wr_pick == IW'(SLOT_COUNT - 1)) ? '0 : wr_pick + 1'b1;
					r_granted = 1'b1;
					r_gslot   = wr_pick[0];
				end
			end
			K_COMMIT: begin
				if (wide_bad) begin
					r_status = ST_BAD_PARAM;
				end else if (dnr_q) begin
					r_status = ST_NOT_READY;
				end else if (!held_valid_q || slot_state_q[held_slot_q] != SL_WRITING) begin
					r_status = ST_BUSY;
				end else begin
					a_fill[held_slot_q]  = size_s1;
					a_sent[held_slot_q]  = '0;
					a_state[held_slot_q] = SL_READY;
					a_held_v  = 1'b0;
					want_feed = 1'b1;
				end
			end
			K_CANCEL: begin
				if (held_valid_q && slot_state_q[held_slot_q] == SL_WRITING) begin
					a_state[held_slot_q] = SL_EMPTY;
				end
				a_held_v = 1'b0;
			end
			K_PIN: begin
				want_feed = 1'b1;
			end
			K_DONE: begin
				if (tx_q && act_valid_q) begin
					sum = slot_sent_q[act_slot_q] + SIZE_W'(pend_q);
					a_sent[act_slot_q] = sum;
					a_total = total_q + TOTAL_W'(pend_q);
					a_pend  = '0;
					a_tx    = 1'b0;
					// drained: free the slot
					if (sum >= slot_fill_q[act_slot_q]) begin
						a_state[act_slot_q] = SL_EMPTY;
						a_act_v = 1'b0;
					end
					want_feed = 1'b1;
				end
			end
			K_ERROR: begin
				a_tx     = 1'b0;
				a_paused = 1'b1;
				a_dnr    = 1'b1;
			end
			K_PAUSE: begin
				a_paused = 1'b1;
			end
			K_RESUME: begin
				a_paused  = 1'b0;
				want_feed = 1'b1;
			end
			K_ABORT, K_REINIT: begin
				r_stop = tx_q;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					a_state[i] = SL_EMPTY;
				end
				a_held_v = 1'b0;
				a_held   = '0;
				a_act_v  = 1'b0;
				a_act    = '0;
				a_nw     = '0;
				a_nr     = '0;
				a_tx     = 1'b0;
				a_paused = 1'b0;
				a_pend   = '0;
				a_total  = '0;
				if (kind_s1 == K_REINIT) begin
					a_dnr = 1'b0;
				end
			end
			default: begin
				r_status = ST_BAD_PARAM;
			end
		endcase
	end

	// ---------------- feed step ----------------
	logic [SLOT_COUNT-1:0] ready_vec;
	logic                  rd_found;
	logic [IW-1:0]         rd_pick;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			ready_vec[i] = (a_state[i] == SL_READY);
		end
	end

	ppsf_rr_pick #(.SLOT_COUNT(SLOT_COUNT)) u_rd_pick (
		.req   (ready_vec),
		.first (a_nr),
		.found (rd_found),
		.pick  (rd_pick)
	);

	slot_st_t           b_state [SLOT_COUNT];
	logic               b_act_v, b_tx, f_start, b_idle;
	logic [IW-1:0]      b_act, b_nr, f_idx;
	logic [PW-1:0]      b_pend;
	logic [SIZE_W-1:0]  f_offset;

	always_comb begin
		logic              go;
		logic [SIZE_W-1:0] rem;
		b_state  = a_state;
		b_act_v  = a_act_v;
		b_act    = a_act;
		b_nr     = a_nr;
		b_tx     = a_tx;
		b_pend   = a_pend;
		f_start  = 1'b0;
		f_idx    = '0;
		f_offset = '0;
		rem      = '0;
		go = want_feed && !a_dnr && !a_paused && !a_tx && pin_s1;
		// pick up the next ready slot when nothing is active
		if (go && !a_act_v && rd_found) begin
			b_act_v          = 1'b1;
			b_act            = rd_pick;
			b_nr             = (rd_pick == IW'(SLOT_COUNT - 1)) ? '0 : rd_pick + 1'b1;
			b_state[rd_pick] = SL_ACTIVE;
		end
		if (go && b_act_v) begin
			rem = (a_fill[b_act] >= a_sent[b_act]) ? a_fill[b_act] - a_sent[b_act] : '0;
			b_pend   = (rem > SIZE_W'(CHUNK_BYTES)) ? PW'(CHUNK_BYTES) : PW'(rem);
			b_tx     = 1'b1;
			f_start  = 1'b1;
			f_idx    = b_act;
			f_offset = a_sent[b_act];
		end
		b_idle = !b_tx && !a_held_v && !b_act_v;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (b_state[i] != SL_EMPTY) begin
				b_idle = 1'b0;
			end
		end
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_state_q[i] <= SL_EMPTY;
			end
			held_valid_q <= 1'b0;
			held_slot_q  <= '0;
			act_valid_q  <= 1'b0;
			act_slot_q   <= '0;
			next_wr_q    <= '0;
			next_rd_q    <= '0;
			tx_q         <= 1'b0;
			paused_q     <= 1'b0;
			pend_q       <= '0;
			total_q      <= '0;
			dnr_q        <= 1'b1;
		end else if (valid_s1) begin
			slot_state_q <= b_state;
			held_valid_q <= a_held_v;
			held_slot_q  <= a_held;
			act_valid_q  <= b_act_v;
			act_slot_q   <= b_act;
			next_wr_q    <= a_nw;
			next_rd_q    <= b_nr;
			tx_q         <= b_tx;
			paused_q     <= a_paused;
			pend_q       <= b_pend;
			total_q      <= a_total;
			dnr_q        <= a_dnr;
		end
	end

	// fill and sent counts are only read for slots that were committed
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			slot_fill_q <= a_fill;
			slot_sent_q <= a_sent;
		end
	end

	// ---------------- result register ----------------
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status     <= r_status;
			granted    <= r_granted;
			grant_slot <= r_gslot;
			dma_start  <= f_start;
			dma_slot   <= f_idx[0];
			dma_offset <= f_offset[OFFSET_W-1:0];
			dma_length <= f_start ? LENGTH_W'(b_pend) : '0;
			dma_stop   <= r_stop;
			in_flight  <= b_tx;
			idle       <= b_idle;
			bytes_sent <= a_total;
		end
	end

	assign done = done_q;

	// ---------------- checks ----------------
	logic [SLOT_COUNT-1:0] active_vec;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			active_vec[i] = (slot_state_q[i] == SL_ACTIVE);
		end
	end

`ifndef SYNTHESIS
	a_tx_has_active: assert property (@(posedge clk) disable iff (!arst_n)
		tx_q |-> act_valid_q)
		else $error("chunk in flight without an active slot");

	a_one_active: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(active_vec) <= 1)
		else $error("more than one slot active");

	a_active_matches: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid_q |-> slot_state_q[act_slot_q] == SL_ACTIVE)
		else $error("active slot not marked active");

	a_held_writing: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> slot_state_q[held_slot_q] == SL_WRITING)
		else $error("held slot not in writing state");

	a_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(dma_start && dma_stop))
		else $error("chunk launched and stopped in one result");
`endif

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ping-pong stream feeder. Commands go in over
// the start/busy port. An in-bench copy of the slot table predicts every
// result. Each done strobe is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
	import ppsf_pkg::*;

	localparam int unsigned NSLOT     = SLOT_COUNT_DEF;
	localparam int unsigned SLOT_MAX  = SLOT_BYTES_DEF;
	localparam int unsigned CHUNK_MAX = CHUNK_BYTES_DEF;
	localparam int unsigned RANDOM_ITEMS = 1350;

	// highest kind code; the codes above reinit are not decoded
	localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SIZE_W-1:0] size;
		logic              pin;
	} feeder_cmd_t;

	typedef struct packed {
		status_t             status;
		logic                granted;
		logic                grant_slot;
		logic                dma_start;
		logic                dma_slot;
		logic [OFFSET_W-1:0] dma_offset;
		logic [LENGTH_W-1:0] dma_length;
		logic                dma_stop;
		logic                in_flight;
		logic                idle;
		logic [TOTAL_W-1:0]  bytes_sent;
	} feeder_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [KIND_W-1:0] kind = K_ACQUIRE;
	logic [SIZE_W-1:0] commit_size = '0;
	logic sink_ready = 1'b0;
	logic busy, done, granted, grant_slot, dma_start, dma_slot;
	logic dma_stop, in_flight, idle;
	logic [STATUS_W-1:0] status;
	logic [OFFSET_W-1:0] dma_offset;
	logic [LENGTH_W-1:0] dma_length;
	logic [TOTAL_W-1:0] bytes_sent;

	ping_pong_stream_feeder DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .commit_size(commit_size), .sink_ready(sink_ready),
		.done(done), .status(status), .granted(granted), .grant_slot(grant_slot),
		.dma_start(dma_start), .dma_slot(dma_slot), .dma_offset(dma_offset),
		.dma_length(dma_length), .dma_stop(dma_stop), .in_flight(in_flight),
		.idle(idle), .bytes_sent(bytes_sent)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hold reset, then release it away from the rising edge.
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// Predicted feeder state
	// ------------------------------------------------------------------
	slot_st_t          slot_st   [NSLOT];
	logic [SIZE_W-1:0] slot_fill [NSLOT];
	logic [SIZE_W-1:0] slot_sent [NSLOT];
	logic              held_v, act_v, chunk_busy, paused, decoder_off = 1'b1;
	int unsigned       held_idx, act_idx, wr_ptr, rd_ptr;
	logic [LENGTH_W-1:0] chunk_len;
	logic [TOTAL_W-1:0]  total_bytes;
	feeder_result_t    prediction;

	int unsigned grant_count = 0, launch_count = 0, stop_count = 0;
	int unsigned transfer_count = 0, result_count = 0, mismatch_count = 0;

	feeder_cmd_t    command_queue[$];
	feeder_result_t expected_results[$];
	feeder_cmd_t    drive_cmd;
	feeder_result_t want_result;
	logic           accepted = 1'b0;
	int unsigned    gap_left = 0;
	logic           gap_burst = 1'b0;

	// Return every slot, the hold, the active pointer and the total to reset.
	function automatic void clear_stream();
		int unsigned i;
		for (i = 0; i < NSLOT; i++) begin
			slot_st[i]   = SL_EMPTY;
			slot_fill[i] = '0;
			slot_sent[i] = '0;
		end
		held_v = 1'b0;
		held_idx = 0;
		act_v = 1'b0;
		act_idx = 0;
		wr_ptr = 0;
		rd_ptr = 0;
		chunk_busy = 1'b0;
		paused = 1'b0;
		chunk_len = '0;
		total_bytes = '0;
	endfunction

	// Launch the next chunk when the sink, the decoder and the stream allow it.
	function automatic void launch_chunk(input logic pin);
		int unsigned scan, idx;
		logic found;
		logic [SIZE_W-1:0] remain;
		if (decoder_off || paused || chunk_busy || !pin)
			return;
		if (!act_v) begin
			found = 1'b0;
			for (scan = 0; scan < NSLOT; scan++) begin
				idx = (rd_ptr + scan) % NSLOT;
				if (!found && slot_st[idx] == SL_READY) begin
					found = 1'b1;
					act_v = 1'b1;
					act_idx = idx;
					rd_ptr = (idx + 1) % NSLOT;
					slot_st[idx] = SL_ACTIVE;
				end
			end
		end
		if (!act_v)
			return;
		idx = act_idx;
		remain = (slot_fill[idx] >= slot_sent[idx]) ? slot_fill[idx] - slot_sent[idx] : '0;
		chunk_len = (32'(remain) > CHUNK_MAX) ? LENGTH_W'(CHUNK_MAX) : LENGTH_W'(remain);
		chunk_busy = 1'b1;
		prediction.dma_start  = 1'b1;
		prediction.dma_slot   = idx[0];
		prediction.dma_offset = slot_sent[idx][OFFSET_W-1:0];
		prediction.dma_length = chunk_len;
		launch_count++;
	endfunction

	// Apply one command to the predicted state and return the result it causes.
	function automatic feeder_result_t advance_feeder(input logic [KIND_W-1:0] k,
			input logic [SIZE_W-1:0] size, input logic pin);
		int unsigned scan, idx;
		logic found;
		prediction = '0;
		prediction.status = ST_OK;
		case (k)
			K_ACQUIRE: begin
				if (decoder_off)
					prediction.status = ST_NOT_READY;
				else if (held_v)
					prediction.status = ST_BUSY;
				else begin
					prediction.status = ST_BUSY;
					found = 1'b0;
					for (scan = 0; scan < NSLOT; scan++) begin
						idx = (wr_ptr + scan) % NSLOT;
						if (!found && slot_st[idx] == SL_EMPTY) begin
							found = 1'b1;
							slot_st[idx] = SL_WRITING;
							slot_fill[idx] = '0;
							slot_sent[idx] = '0;
							held_v = 1'b1;
							held_idx = idx;
							wr_ptr = (idx + 1) % NSLOT;
							prediction.status = ST_OK;
							prediction.granted = 1'b1;
							prediction.grant_slot = idx[0];
							grant_count++;
						end
					end
				end
			end
			K_COMMIT: begin
				// size check comes ahead of the readiness and hold checks
				if (size == '0 || 32'(size) > SLOT_MAX)
					prediction.status = ST_BAD_PARAM;
				else if (decoder_off)
					prediction.status = ST_NOT_READY;
				else if (!held_v || slot_st[held_idx] != SL_WRITING)
					prediction.status = ST_BUSY;
				else begin
					slot_fill[held_idx] = size;
					slot_sent[held_idx] = '0;
					slot_st[held_idx] = SL_READY;
					held_v = 1'b0;
					launch_chunk(pin);
				end
			end
			K_CANCEL: begin
				if (held_v && slot_st[held_idx] == SL_WRITING) begin
					slot_st[held_idx] = SL_EMPTY;
					slot_fill[held_idx] = '0;
					slot_sent[held_idx] = '0;
				end
				held_v = 1'b0;
			end
			K_PIN: launch_chunk(pin);
			K_DONE: begin
				// drop a completion that has no chunk behind it
				if (chunk_busy && act_v) begin
					idx = act_idx;
					slot_sent[idx] = slot_sent[idx] + SIZE_W'(chunk_len);
					total_bytes = total_bytes + TOTAL_W'(chunk_len);
					chunk_len = '0;
					chunk_busy = 1'b0;
					if (slot_sent[idx] >= slot_fill[idx]) begin
						slot_st[idx] = SL_EMPTY;
						slot_fill[idx] = '0;
						slot_sent[idx] = '0;
						act_v = 1'b0;
					end
					launch_chunk(pin);
				end
			end
			K_ERROR: begin
				// keep the active slot's progress, fault the decoder
				chunk_busy = 1'b0;
				paused = 1'b1;
				decoder_off = 1'b1;
			end
			K_PAUSE: paused = 1'b1;
			K_RESUME: begin
				paused = 1'b0;
				launch_chunk(pin);
			end
			K_ABORT, K_REINIT: begin
				prediction.dma_stop = chunk_busy;
				if (chunk_busy)
					stop_count++;
				clear_stream();
				if (k == K_REINIT)
					decoder_off = 1'b0;
			end
			default: prediction.status = ST_BAD_PARAM;
		endcase
		prediction.idle = !chunk_busy && !held_v && !act_v;
		for (idx = 0; idx < NSLOT; idx++)
			if (slot_st[idx] != SL_EMPTY)
				prediction.idle = 1'b0;
		prediction.in_flight = chunk_busy;
		prediction.bytes_sent = total_bytes;
		return prediction;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("ERROR result %0d: %s", result_count, msg);
	endtask

	task automatic check_field(input string name, input logic [TOTAL_W-1:0] got,
			input logic [TOTAL_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// Sample both sides at the rising edge: predict each transfer, compare
	// each strobed result with the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n)
			accepted <= 1'b0;
		else begin
			accepted <= start && !busy;
			if (start && !busy) begin
				transfer_count++;
				expected_results.push_back(advance_feeder(kind, commit_size, sink_ready));
			end
			if (done) begin
				result_count++;
				if (expected_results.size() == 0)
					report_mismatch("result with no command pending");
				else begin
					want_result = expected_results.pop_front();
					check_field("status", TOTAL_W'(status), TOTAL_W'(want_result.status));
					check_field("granted", TOTAL_W'(granted), TOTAL_W'(want_result.granted));
					check_field("grant_slot", TOTAL_W'(grant_slot),
						TOTAL_W'(want_result.grant_slot));
					check_field("dma_start", TOTAL_W'(dma_start),
						TOTAL_W'(want_result.dma_start));
					check_field("dma_slot", TOTAL_W'(dma_slot), TOTAL_W'(want_result.dma_slot));
					check_field("dma_offset", TOTAL_W'(dma_offset),
						TOTAL_W'(want_result.dma_offset));
					check_field("dma_length", TOTAL_W'(dma_length),
						TOTAL_W'(want_result.dma_length));
					check_field("dma_stop", TOTAL_W'(dma_stop), TOTAL_W'(want_result.dma_stop));
					check_field("in_flight", TOTAL_W'(in_flight),
						TOTAL_W'(want_result.in_flight));
					check_field("idle", TOTAL_W'(idle), TOTAL_W'(want_result.idle));
					check_field("bytes_sent", bytes_sent, want_result.bytes_sent);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------
	// Draw the idle gap that follows a command, with runs of back-to-back commands.
	function automatic int unsigned draw_gap();
		if ($urandom_range(0, 31) == 0)
			gap_burst = !gap_burst;
		return gap_burst ? 0 : $urandom_range(0, 4);
	endfunction

	// Change inputs on the falling edge; hold a command until it transfers.
	always @(negedge clk) begin
		if (!arst_n)
			start <= 1'b0;
		else if (start && !accepted) begin
			// hold: the block has not taken the command yet
		end else if (gap_left != 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (command_queue.size() != 0) begin
			drive_cmd = command_queue.pop_front();
			kind <= drive_cmd.kind;
			commit_size <= drive_cmd.size;
			sink_ready <= drive_cmd.pin;
			start <= 1'b1;
			gap_left <= draw_gap();
		end else
			start <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic push_cmd(input logic [KIND_W-1:0] k, input logic [SIZE_W-1:0] size,
			input logic pin);
		feeder_cmd_t c;
		c.kind = k;
		c.size = size;
		c.pin = pin;
		command_queue.push_back(c);
	endtask

	// Mostly short payloads, some longer ones up to and at the full slot, some illegal.
	function automatic logic [SIZE_W-1:0] draw_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return SIZE_W'($urandom_range(1, 96));
		if (r < 93)
			return SIZE_W'($urandom_range(97, SLOT_MAX));
		if (r < 96)
			return SIZE_W'(SLOT_MAX);
		return ($urandom_range(0, 1) != 0) ? '0 : SIZE_W'($urandom_range(SLOT_MAX + 1, 8191));
	endfunction

	function automatic logic draw_pin();
		return $urandom_range(0, 4) != 0;
	endfunction

	function automatic logic [SIZE_W-1:0] draw_any_size();
		return SIZE_W'($urandom_range(0, 8191));
	endfunction

	task automatic push_random_traffic();
		int unsigned r, n, i, j;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			// produce-and-drain with random sizes, some illegal, and pin levels
			push_cmd(K_ACQUIRE, draw_any_size(), draw_pin());
			if ($urandom_range(0, 99) < 8) begin
				push_cmd(K_CANCEL, draw_any_size(), draw_pin());
				return;
			end
			push_cmd(K_COMMIT, draw_size(), draw_pin());
			n = $urandom_range(1, 6);
			for (i = 0; i < n; i++) begin
				j = $urandom_range(0, 9);
				if (j < 7)
					push_cmd(K_DONE, '0, draw_pin());
				else if (j < 9)
					push_cmd(K_PIN, '0, draw_pin());
				else begin
					push_cmd(K_PAUSE, '0, draw_pin());
					push_cmd(K_RESUME, '0, draw_pin());
				end
			end
		end else if (r < 80) begin
			// drain run to empty the slots
			n = $urandom_range(10, 40);
			push_cmd(K_PIN, '0, 1'b1);
			for (i = 0; i < n; i++)
				push_cmd(K_DONE, '0, 1'b1);
		end else if (r < 92)
			push_cmd(KIND_W'($urandom_range(0, 32'(KIND_UNUSED_HI))), draw_any_size(),
				$urandom_range(0, 1) != 0);
		else if (r < 96) begin
			push_cmd(K_ERROR, draw_any_size(), draw_pin());
			if ($urandom_range(0, 1) != 0)
				push_cmd(K_RESUME, '0, 1'b1);
			push_cmd(K_ACQUIRE, '0, 1'b1);
			push_cmd(K_REINIT, '0, draw_pin());
		end else begin
			push_cmd(K_ABORT, draw_any_size(), draw_pin());
			if ($urandom_range(0, 1) != 0)
				push_cmd(K_REINIT, '0, draw_pin());
		end
	endtask

	initial begin
		int unsigned drain_wait;

		clear_stream();

		// Decoder still not ready out of reset: every request ahead of the reinit is refused.
		push_cmd(K_ACQUIRE, '0, 1'b0);
		push_cmd(K_COMMIT, '0, 1'b1);
		push_cmd(K_COMMIT, SIZE_W'(SLOT_MAX + 1), 1'b1);
		push_cmd(K_COMMIT, 13'd100, 1'b1);
		push_cmd(KIND_UNUSED_HI, 13'h1fff, 1'b1);
		push_cmd(K_REINIT, '0, 1'b0);
		// Hold, grant and commit paths, feed gated by the ready pin.
		push_cmd(K_CANCEL, '0, 1'b0);
		push_cmd(K_ACQUIRE, '0, 1'b1);
		push_cmd(K_ACQUIRE, '0, 1'b1);
		push_cmd(K_COMMIT, SIZE_W'(SLOT_MAX), 1'b0);
		push_cmd(K_PIN, '0, 1'b1);
		push_cmd(K_ACQUIRE, '0, 1'b0);
		push_cmd(K_COMMIT, 13'h1fff, 1'b1);
		push_cmd(K_COMMIT, 13'd33, 1'b1);
		push_cmd(K_ACQUIRE, '0, 1'b1);
		// Completion, pause with a chunk in flight, resume, abort mid-chunk.
		push_cmd(K_DONE, '0, 1'b1);
		push_cmd(K_PAUSE, '0, 1'b1);
		push_cmd(K_DONE, '0, 1'b1);
		push_cmd(K_RESUME, '0, 1'b1);
		push_cmd(K_ABORT, '0, 1'b1);
		push_cmd(K_DONE, '0, 1'b0);
		push_cmd(K_ACQUIRE, '0, 1'b1);
		push_cmd(K_CANCEL, '0, 1'b1);
		// Transfer error: fault, then resume launches nothing and acquire is refused.
		push_cmd(K_ACQUIRE, '0, 1'b1);
		push_cmd(K_COMMIT, 13'd1, 1'b1);
		push_cmd(K_ERROR, '0, 1'b1);
		push_cmd(K_RESUME, '0, 1'b1);
		push_cmd(K_ACQUIRE, '0, 1'b1);
		push_cmd(K_REINIT, '0, 1'b1);

		while (command_queue.size() < RANDOM_ITEMS)
			push_random_traffic();

		// Advance until every command has transferred and its result came back.
		@(posedge arst_n);
		while (command_queue.size() != 0 || start)
			@(posedge clk);
		drain_wait = 0;
		while (expected_results.size() != 0 && drain_wait < 64) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("ran %0d commands, checked %0d results", transfer_count, result_count);
		$display("%0d grants, %0d chunk launches, %0d stops of a chunk in flight",
			grant_count, launch_count, stop_count);
		if (mismatch_count == 0)
			$display("ping_pong_stream_feeder: match");
		else
			$display("ping_pong_stream_feeder: mismatch");
		$finish;
	end

	// Stop a hung run long after the slowest correct one would have ended.
	initial begin
		#3000000;
		$display("ping_pong_stream_feeder: mismatch");
		$finish;
	end

endmodule
